[hw/rtl/bdsm_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, fixed-point constants and pipeline stage numbering for the
// barrel distortion scatter map. No dependencies.
package bdsm_pkg;

    // Fixed-point format and frame limits
    localparam int FRAC_BITS = 18;
    localparam int DIM_W     = 12;
    localparam int COORD_W   = 11;
    localparam int PIXEL_W   = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] MIN_DIM      = DIM_W'(2);
    localparam logic [DIM_W-1:0] MAX_DIM      = DIM_W'(2048);
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // Quotient of 2c/dim in fixed point: at most 2.0 for in-frame coordinates
    localparam int QUOT_W     = FRAC_BITS + 2;
    localparam int DIV_STAGES = 5;
    localparam int DIV_BITS   = (QUOT_W + DIV_STAGES - 1) / DIV_STAGES;

    localparam logic [QUOT_W-1:0] ONE_Q = QUOT_W'(1) << FRAC_BITS;

    // Datapath widths
    localparam int NORM_W  = FRAC_BITS + 2;           // signed, [-1, 1]
    localparam int SQ_W    = FRAC_BITS + 1;           // unsigned, [0, 1]
    localparam int R2_W    = FRAC_BITS + 2;           // unsigned, [0, 2]
    localparam int S_W     = FRAC_BITS + 1;           // unsigned, [0, 1]
    localparam int PROD_W  = NORM_W + S_W + 1;        // signed product
    localparam int T_W     = FRAC_BITS + 2;           // unsigned, [0, 2]
    localparam int SCALE_W = T_W + DIM_W;

    // Pipeline stage numbering
    localparam int ST_IN    = 0;
    localparam int ST_DIV0  = 1;
    localparam int ST_SQ    = ST_DIV0 + DIV_STAGES;
    localparam int ST_R2    = ST_SQ + 1;
    localparam int ST_MUL   = ST_R2 + 1;
    localparam int ST_SCALE = ST_MUL + 1;
    localparam int ST_OUT   = ST_SCALE + 1;
    localparam int N_STAGES = ST_OUT + 1;

endpackage

[hw/rtl/bdsm_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider: floor((coord << (FRAC_BITS+1)) / dim).
// Depends on bdsm_pkg.
module bdsm_div (
    input  logic                                aclk,
    input  logic [bdsm_pkg::DIV_STAGES-1:0]     stage_en,
    input  logic [bdsm_pkg::COORD_W-1:0]        coord,
    input  logic [bdsm_pkg::DIM_W-1:0]          dim,
    output logic [bdsm_pkg::QUOT_W-1:0]         quot
);

    logic [bdsm_pkg::DIM_W-1:0]      rem_reg  [bdsm_pkg::DIV_STAGES];
    logic [bdsm_pkg::QUOT_W-1:0]     quot_reg [bdsm_pkg::DIV_STAGES];
    logic [bdsm_pkg::DIM_W-1:0]      rem_in   [bdsm_pkg::DIV_STAGES];
    logic [bdsm_pkg::QUOT_W-1:0]     quot_in  [bdsm_pkg::DIV_STAGES];
    logic [bdsm_pkg::DIV_STAGES-1:0] head_bit;

    for (genvar g = 0; g < bdsm_pkg::DIV_STAGES; g++) begin : g_stage
        logic [bdsm_pkg::DIM_W-1:0]  rem_next;
        logic [bdsm_pkg::QUOT_W-1:0] quot_next;

        if (g == 0) begin : g_first
            // Numerator bits above the quotient window seed the remainder;
            // the lowest coordinate bit is the only non-zero bit left.
            assign rem_in[g]   = bdsm_pkg::DIM_W'(coord[bdsm_pkg::COORD_W-1:1]);
            assign quot_in[g]  = '0;
            assign head_bit[g] = coord[0];
        end else begin : g_rest
            assign rem_in[g]   = rem_reg[g-1];
            assign quot_in[g]  = quot_reg[g-1];
            assign head_bit[g] = 1'b0;
        end

        always_comb begin
            logic [bdsm_pkg::DIM_W:0]    trial;
            logic [bdsm_pkg::DIM_W-1:0]  rem;
            logic [bdsm_pkg::QUOT_W-1:0] q;
            rem   = rem_in[g];
            q     = quot_in[g];
            trial = '0;
            for (int i = 0; i < bdsm_pkg::DIV_BITS; i++) begin
                if (g * bdsm_pkg::DIV_BITS + i < bdsm_pkg::QUOT_W) begin
                    trial = {rem, ((i == 0) ? head_bit[g] : 1'b0)};
                    q     = {q[bdsm_pkg::QUOT_W-2:0], 1'b0};
                    if (trial >= {1'b0, dim}) begin
                        trial = trial - {1'b0, dim};
                        q[0]  = 1'b1;
                    end
                    rem = trial[bdsm_pkg::DIM_W-1:0];
                end
            end
            rem_next  = rem;
            quot_next = q;
        end

        always_ff @(posedge aclk) begin
            if (stage_en[g]) begin
                rem_reg[g]  <= rem_next;
                quot_reg[g] <= quot_next;
            end
        end
    end

    assign quot = quot_reg[bdsm_pkg::DIV_STAGES-1];

endmodule

[hw/rtl/barrel_distortion_scatter_map_unit.sv]
`timescale 1ns / 1ps
// Barrel distortion scatter map: top level with configuration registers and
// the full mapping pipeline. Depends on bdsm_pkg and bdsm_div.
//
//  Channel  | Prefix | Direction | Carries
//  ---------+--------+-----------+-------------------------------------------
//  source   | s_     | in        | src_col, src_row, pixel
//  result   | m_     | out       | dest_col, dest_row, write_enable, pixel_out
//  config   | cfg_   | in        | register index and write data
//
// One transfer per clock in and out when the result side keeps up. A result
// passes from its source transfer through eleven register stages: input,
// the five-stage divider (four quotient bits per stage), square, radius,
// product, scale and output.
// Every stage holds a valid bit; a stage loads whenever it is empty or the
// stage after it moves, so bubbles close up and the source side keeps taking
// transfers while a result waits at the output, until every stage is full.
// aresetn (synchronous) clears the valid bits and returns the frame size to
// 640 x 480. Configuration writes are taken in any cycle.
module barrel_distortion_scatter_map_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // source channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bdsm_pkg::COORD_W-1:0]      s_src_col,
    input  logic [bdsm_pkg::COORD_W-1:0]      s_src_row,
    input  logic [bdsm_pkg::PIXEL_W-1:0]      s_pixel,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bdsm_pkg::COORD_W-1:0]      m_dest_col,
    output logic [bdsm_pkg::COORD_W-1:0]      m_dest_row,
    output logic                              m_write_enable,
    output logic [bdsm_pkg::PIXEL_W-1:0]      m_pixel_out,
    // configuration channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bdsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bdsm_pkg::DIM_W-1:0]        cfg_data
);

    // ------------------------------------------------------------------
    // Configuration: hold the frame size already clamped to [2, MAX_DIM]
    // ------------------------------------------------------------------
    logic [bdsm_pkg::DIM_W-1:0] wdim_reg, hdim_reg;
    logic [bdsm_pkg::DIM_W-1:0] cfg_dim;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_dim = cfg_data;
        if (cfg_data < bdsm_pkg::MIN_DIM) begin
            cfg_dim = bdsm_pkg::MIN_DIM;
        end else if (cfg_data > bdsm_pkg::MAX_DIM) begin
            cfg_dim = bdsm_pkg::MAX_DIM;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wdim_reg <= bdsm_pkg::WIDTH_RESET;
            hdim_reg <= bdsm_pkg::HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bdsm_pkg::REG_IMAGE_WIDTH:  wdim_reg <= cfg_dim;
                bdsm_pkg::REG_IMAGE_HEIGHT: hdim_reg <= cfg_dim;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage control: valid bits and per-stage load enables
    // ------------------------------------------------------------------
    logic [bdsm_pkg::N_STAGES-1:0] vld_reg;
    logic [bdsm_pkg::N_STAGES-1:0] en;

    // A stage loads when it is empty or its contents move on this edge.
    always_comb begin
        en[bdsm_pkg::N_STAGES-1] = !vld_reg[bdsm_pkg::N_STAGES-1] || m_ready;
        for (int k = bdsm_pkg::N_STAGES - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[bdsm_pkg::ST_IN]) begin
                vld_reg[bdsm_pkg::ST_IN] <= s_valid;
            end
            for (int k = 1; k < bdsm_pkg::N_STAGES; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign s_ready = en[bdsm_pkg::ST_IN];
    assign m_valid = vld_reg[bdsm_pkg::ST_OUT];

    // ------------------------------------------------------------------
    // Side band: pixel and in-frame flag travel with the item
    // ------------------------------------------------------------------
    logic [bdsm_pkg::PIXEL_W-1:0] pix_reg [bdsm_pkg::N_STAGES];
    logic                         inr_reg [bdsm_pkg::ST_SQ+1];

    always_ff @(posedge aclk) begin
        if (en[bdsm_pkg::ST_IN]) begin
            pix_reg[bdsm_pkg::ST_IN] <= s_pixel;
            // A coordinate past the dimension normalises above one: no write.
            inr_reg[bdsm_pkg::ST_IN] <= ({1'b0, s_src_col} <= wdim_reg) &&
                                        ({1'b0, s_src_row} <= hdim_reg);
        end
        for (int k = 1; k < bdsm_pkg::N_STAGES; k++) begin
            if (en[k]) begin
                pix_reg[k] <= pix_reg[k-1];
            end
        end
        for (int k = 1; k <= bdsm_pkg::ST_SQ; k++) begin
            if (en[k]) begin
                inr_reg[k] <= inr_reg[k-1];
            end
        end
    end

    assign m_pixel_out = pix_reg[bdsm_pkg::ST_OUT];

    // ------------------------------------------------------------------
    // Input stage and normalising division
    // ------------------------------------------------------------------
    logic [bdsm_pkg::COORD_W-1:0] x_reg, y_reg;
    logic [bdsm_pkg::QUOT_W-1:0]  quot_x, quot_y;

    always_ff @(posedge aclk) begin
        if (en[bdsm_pkg::ST_IN]) begin
            x_reg <= s_src_col;
            y_reg <= s_src_row;
        end
    end

    bdsm_div u_div_x (
        .aclk     (aclk),
        .stage_en (en[bdsm_pkg::ST_DIV0 +: bdsm_pkg::DIV_STAGES]),
        .coord    (x_reg),
        .dim      (wdim_reg),
        .quot     (quot_x)
    );

    bdsm_div u_div_y (
        .aclk     (aclk),
        .stage_en (en[bdsm_pkg::ST_DIV0 +: bdsm_pkg::DIV_STAGES]),
        .coord    (y_reg),
        .dim      (hdim_reg),
        .quot     (quot_y)
    );

    // ------------------------------------------------------------------
    // Square stage: n = 2c/dim - 1, and n^2 floored to FRAC_BITS
    // ------------------------------------------------------------------
    logic signed [bdsm_pkg::NORM_W-1:0]   nx_next, ny_next;
    logic signed [2*bdsm_pkg::NORM_W-1:0] sqx_full, sqy_full;
    logic signed [bdsm_pkg::NORM_W-1:0]   nx_reg, ny_reg;
    logic [bdsm_pkg::SQ_W-1:0]            sqx_reg, sqy_reg;

    always_comb begin
        nx_next  = $signed(bdsm_pkg::NORM_W'(quot_x - bdsm_pkg::ONE_Q));
        ny_next  = $signed(bdsm_pkg::NORM_W'(quot_y - bdsm_pkg::ONE_Q));
        sqx_full = nx_next * nx_next;
        sqy_full = ny_next * ny_next;
    end

    always_ff @(posedge aclk) begin
        if (en[bdsm_pkg::ST_SQ]) begin
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
            sqx_reg <= sqx_full[2*bdsm_pkg::FRAC_BITS:bdsm_pkg::FRAC_BITS];
            sqy_reg <= sqy_full[2*bdsm_pkg::FRAC_BITS:bdsm_pkg::FRAC_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Radius stage: r2, the unit-circle test and s = 1 - r2/2
    // ------------------------------------------------------------------
    logic [bdsm_pkg::R2_W-1:0]          r2;
    logic signed [bdsm_pkg::NORM_W-1:0] nx2_reg, ny2_reg;
    logic [bdsm_pkg::S_W-1:0]           s_reg;
    logic                               we_r2_reg;

    assign r2 = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge aclk) begin
        if (en[bdsm_pkg::ST_R2]) begin
            nx2_reg   <= nx_reg;
            ny2_reg   <= ny_reg;
            s_reg     <= bdsm_pkg::S_W'(bdsm_pkg::ONE_Q) - bdsm_pkg::S_W'(r2 >> 1);
            we_r2_reg <= inr_reg[bdsm_pkg::ST_SQ] &&
                         (r2 <= bdsm_pkg::R2_W'(bdsm_pkg::ONE_Q));
        end
    end

    // ------------------------------------------------------------------
    // Product stage: n * s
    // ------------------------------------------------------------------
    logic signed [bdsm_pkg::PROD_W-1:0] px_reg, py_reg;
    logic                               we_mul_reg;

    always_ff @(posedge aclk) begin
        if (en[bdsm_pkg::ST_MUL]) begin
            px_reg     <= nx2_reg * $signed({1'b0, s_reg});
            py_reg     <= ny2_reg * $signed({1'b0, s_reg});
            we_mul_reg <= we_r2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Scale stage: t = floor(n*s) + 1, clamped at zero, times the dimension
    // ------------------------------------------------------------------
    logic signed [bdsm_pkg::PROD_W-1:0] tx_full, ty_full;
    logic [bdsm_pkg::T_W-1:0]           tx, ty;
    logic [bdsm_pkg::SCALE_W-1:0]       scx_reg, scy_reg;
    logic                               we_sc_reg;

    always_comb begin
        tx_full = (px_reg >>> bdsm_pkg::FRAC_BITS) +
                  $signed(bdsm_pkg::PROD_W'(bdsm_pkg::ONE_Q));
        ty_full = (py_reg >>> bdsm_pkg::FRAC_BITS) +
                  $signed(bdsm_pkg::PROD_W'(bdsm_pkg::ONE_Q));
        tx = tx_full[bdsm_pkg::PROD_W-1] ? '0 : tx_full[bdsm_pkg::T_W-1:0];
        ty = ty_full[bdsm_pkg::PROD_W-1] ? '0 : ty_full[bdsm_pkg::T_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en[bdsm_pkg::ST_SCALE]) begin
            scx_reg   <= tx * wdim_reg;
            scy_reg   <= ty * hdim_reg;
            we_sc_reg <= we_mul_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: divide by two in fixed point, zero when disabled
    // ------------------------------------------------------------------
    logic [bdsm_pkg::COORD_W-1:0] dest_col_reg, dest_row_reg;
    logic                         we_out_reg;

    always_ff @(posedge aclk) begin
        if (en[bdsm_pkg::ST_OUT]) begin
            we_out_reg   <= we_sc_reg;
            dest_col_reg <= we_sc_reg ?
                            scx_reg[bdsm_pkg::FRAC_BITS+1 +: bdsm_pkg::COORD_W] : '0;
            dest_row_reg <= we_sc_reg ?
                            scy_reg[bdsm_pkg::FRAC_BITS+1 +: bdsm_pkg::COORD_W] : '0;
        end
    end

    assign m_dest_col     = dest_col_reg;
    assign m_dest_row     = dest_row_reg;
    assign m_write_enable = we_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_disabled_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_enable |-> (m_dest_col == '0) && (m_dest_row == '0))
        else $error("disabled result carries a non-zero destination");

    a_dim_clamped : assert property (@(posedge aclk) disable iff (!aresetn)
        (wdim_reg >= bdsm_pkg::MIN_DIM) && (wdim_reg <= bdsm_pkg::MAX_DIM) &&
        (hdim_reg >= bdsm_pkg::MIN_DIM) && (hdim_reg <= bdsm_pkg::MAX_DIM))
        else $error("frame size register outside clamped range");

    a_ready_only_when_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&vld_reg) && !m_ready)
        else $error("source stalled while the pipeline has room");

    a_advance_to_output : assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[bdsm_pkg::ST_SCALE] && en[bdsm_pkg::ST_OUT] |=> m_valid)
        else $error("item lost between scale stage and output register");

endmodule
